// ----- design/rfbp_pkg.sv -----
// Shared types and constants for the ring FIFO with bulk pop.
package rfbp_pkg;

   localparam int WORD_W   = 64;
   localparam int TYPE_W   = 2;
   localparam int LIMIT_W  = 4;
   localparam int OCC_W    = 4;
   localparam int STATUS_W = 2;

   // Request codes. Any other code is a status query.
   localparam logic [TYPE_W-1:0] REQ_PUSH = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_POP  = 2'd1;

   // Status codes reported with every result.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } fifo_state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic [TYPE_W-1:0]  req_type;
      logic [WORD_W-1:0]  push_value;
      logic [LIMIT_W-1:0] pop_limit;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0]   data_word;
      logic                data_valid;
      logic                run_last;
      logic [OCC_W-1:0]    occupancy;
      logic [OCC_W-1:0]    free_slots;
      logic                is_empty;
      logic                is_full;
      logic [STATUS_W-1:0] status_code;
   } rsp_payload_type;

endpackage

// ----- design/rfbp_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface rfbp_req_if;
   logic                      valid;
   logic                      ready;
   rfbp_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rfbp_rsp_if;
   logic                      valid;
   logic                      ready;
   rfbp_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/rfbp_cell.sv -----
// One storage cell of the FIFO chain: loads a pushed word or takes its neighbor's word.
module rfbp_cell #(
   parameter int WORD_BITS = 64
) (
   input  logic                    clock,
   input  rfbp_pkg::cell_ctrl_type ctrl,
   input  logic [WORD_BITS-1:0]    load_word,
   input  logic [WORD_BITS-1:0]    next_word,
   output logic [WORD_BITS-1:0]    word_out
);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   // A pop moves every word one cell toward the head; a push fills the first free cell.
   always_comb begin
      word_in = word_ff;
      if (ctrl.shift) begin
         word_in = next_word;
      end else if (ctrl.load) begin
         word_in = load_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

// ----- design/ring_fifo_with_bulk_pop.sv -----
// Top level of the word FIFO with single pushes and bulk pop runs.
//
// Requests arrive as transactions on req_ch and results leave as transactions on
// rsp_ch, both valid/ready channels. The queue holds at most DEPTH-1 words.
// A push or a status query gives one result; a push into a full queue is dropped
// and flagged, and a pop run on an empty queue gives one flagged result.
// A pop run with limit L (zero counts as one) removes min(L, occupancy) words,
// oldest first, one result per word, with run_last set on the final one. Every
// result carries the occupancy after it, the free slots and the empty and full
// flags. Every result is registered; the result of a request, or the first word
// of a pop run, appears in the cycle after the request transaction, and that
// first word is taken in the same cycle as the request. A pop run moves one
// word per cycle while the output register is free, by the shift of the cell
// chain toward its head. While a run is in progress no new request is taken.
// When the receiver stalls, the result stays in the output register and the
// chain holds; a new request is still taken as long as the stalled result is
// being taken in the same cycle. Reset empties the queue at once by clearing
// the count; the word cells are not cleared and are never read before written.
module ring_fifo_with_bulk_pop #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   rfbp_req_if.sink    req_ch,
   rfbp_rsp_if.source  rsp_ch
);

   localparam int NCELL = DEPTH - 1;
   localparam int CNT_W = $clog2(DEPTH);

   // Control state.
   rfbp_pkg::fifo_state_type state_ff, state_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [rfbp_pkg::LIMIT_W-1:0]   remain_ff, remain_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rfbp_pkg::rsp_payload_type      rsp_ff, rsp_in;

   // Cell chain; cell 0 holds the oldest word.
   logic [WORD_BITS-1:0]    cell_word [NCELL];
   rfbp_pkg::cell_ctrl_type cell_ctrl [NCELL];

   logic                           out_free;
   logic                           req_accept;
   logic                           push_do;
   logic                           pop_do;
   logic                           single_do;
   logic                           pop_last;
   logic [rfbp_pkg::STATUS_W-1:0]  status;
   logic [rfbp_pkg::LIMIT_W-1:0]   limit_eff;
   logic [rfbp_pkg::LIMIT_W-1:0]   run_len;
   logic [rfbp_pkg::LIMIT_W-1:0]   remain_cur;

   // The output register can take a new result when empty or being emptied.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == rfbp_pkg::ST_IDLE) && out_free;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // Decode the request and sequence the pop run.
   always_comb begin
      push_do   = 1'b0;
      pop_do    = 1'b0;
      single_do = 1'b0;
      status    = rfbp_pkg::STATUS_OK;

      // A limit of zero counts as one; a run never takes more than is stored.
      limit_eff  = (req_ch.payload.pop_limit == '0) ? rfbp_pkg::LIMIT_W'(1)
                                                   : req_ch.payload.pop_limit;
      run_len    = (8'(limit_eff) < 8'(count_ff)) ? limit_eff
                                                  : rfbp_pkg::LIMIT_W'(count_ff);
      remain_cur = (state_ff == rfbp_pkg::ST_RUN) ? remain_ff : run_len;
      pop_last   = (remain_cur == rfbp_pkg::LIMIT_W'(1));

      if (req_accept) begin
         case (req_ch.payload.req_type)
            rfbp_pkg::REQ_PUSH: begin
               single_do = 1'b1;
               if (count_ff == CNT_W'(NCELL)) begin
                  status = rfbp_pkg::STATUS_DROPPED;
               end else begin
                  push_do = 1'b1;
               end
            end
            rfbp_pkg::REQ_POP: begin
               if (count_ff == '0) begin
                  single_do = 1'b1;
                  status    = rfbp_pkg::STATUS_EMPTY;
               end else begin
                  pop_do = 1'b1;
               end
            end
            default: begin
               single_do = 1'b1;
            end
         endcase
      end else if ((state_ff == rfbp_pkg::ST_RUN) && out_free) begin
         pop_do = 1'b1;
      end

      count_in = count_ff;
      if (push_do) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_do) begin
         count_in = count_ff - CNT_W'(1);
      end

      remain_in = pop_do ? (remain_cur - rfbp_pkg::LIMIT_W'(1)) : remain_ff;

      // Result register: load on a new result, drop once taken.
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (single_do || pop_do) begin
         rsp_valid_in       = 1'b1;
         rsp_in.data_word   = pop_do ? rfbp_pkg::WORD_W'(cell_word[0]) : '0;
         rsp_in.data_valid  = pop_do;
         rsp_in.run_last    = single_do || pop_last;
         rsp_in.occupancy   = rfbp_pkg::OCC_W'(count_in);
         rsp_in.free_slots  = rfbp_pkg::OCC_W'(8'(NCELL) - 8'(count_in));
         rsp_in.is_empty    = (count_in == '0);
         rsp_in.is_full     = (count_in == CNT_W'(NCELL));
         rsp_in.status_code = status;
      end
   end

   // Next state: a run continues until its last word has been emitted.
   always_comb begin
      state_in = state_ff;
      if (pop_do) begin
         state_in = pop_last ? rfbp_pkg::ST_IDLE : rfbp_pkg::ST_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfbp_pkg::ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   // The chain: a push fills the cell at the current count, a pop shifts all cells.
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      logic [WORD_BITS-1:0] next_word;

      if (i == NCELL - 1) begin : g_tail
         assign next_word = cell_word[i];
      end else begin : g_body
         assign next_word = cell_word[i+1];
      end

      assign cell_ctrl[i].load  = push_do && (count_ff == CNT_W'(i));
      assign cell_ctrl[i].shift = pop_do;

      rfbp_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[i]),
         .load_word (req_ch.payload.push_value[WORD_BITS-1:0]),
         .next_word (next_word),
         .word_out  (cell_word[i])
      );
   end

`ifndef SYNTH
   // The count never passes the usable capacity.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NCELL))
      else $error("stored count exceeds capacity");

   // During a run there are always words left to emit and enough stored to cover them.
   a_run_covered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfbp_pkg::ST_RUN) |->
         (remain_ff != '0) && (8'(remain_ff) <= 8'(count_ff)))
      else $error("pop run outlives the stored words");

   // Each emitted word removes exactly one entry.
   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      pop_do |=> count_ff == CNT_W'($past(count_ff) - CNT_W'(1)))
      else $error("pop step did not decrement the count");

   // A pending result that is not the last of its run means the run is still going.
   a_run_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.run_last) |-> (state_ff == rfbp_pkg::ST_RUN))
      else $error("run ended before its final result");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the ring FIFO with bulk pop runs.
`timescale 1ns / 100ps

module testbench;

   // Block configuration and run limits.
   localparam int DEPTH          = 16;
   localparam int CAPACITY       = DEPTH - 1;
   localparam int MAX_WAIT       = 17;
   localparam int RANDOM_ITEMS   = 446;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;

   // Request codes that the package leaves unnamed. Both act as a status query.
   localparam logic [rfbp_pkg::TYPE_W-1:0] REQ_QUERY = 2'd2;
   localparam logic [rfbp_pkg::TYPE_W-1:0] REQ_SPARE = 2'd3;

   localparam logic [rfbp_pkg::WORD_W-1:0] ALL_ONES = {rfbp_pkg::WORD_W{1'b1}};

   logic clock = 1'b0;
   logic reset;

   rfbp_req_if req_ch ();
   rfbp_rsp_if rsp_ch ();

   ring_fifo_with_bulk_pop #(
      .DEPTH(DEPTH),
      .WORD_BITS(rfbp_pkg::WORD_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #6 clock = ~clock;

   // The predictor keeps the words that should be stored, oldest first, and
   // the results that each accepted request should cause, in arrival order.
   logic [rfbp_pkg::WORD_W-1:0] held_words[$];
   rfbp_pkg::rsp_payload_type   awaited_results[$];
   int                          failures = 0;

   // Each side alternates between stretches of random waits and stretches
   // where it never waits, so that gaps land on every part of a pop run.
   bit send_calm = 1'b0;
   int send_stretch_left = 0;
   bit take_calm = 1'b0;
   int take_stretch_left = 0;

   // A result's status fields always describe the occupancy after the result.
   function automatic rfbp_pkg::rsp_payload_type form_result(
         logic [rfbp_pkg::WORD_W-1:0] word, logic carries_word, logic last_of_run,
         logic [rfbp_pkg::STATUS_W-1:0] status);
      rfbp_pkg::rsp_payload_type result;
      int count;
      count = held_words.size();
      result.data_word   = carries_word ? word : '0;
      result.data_valid  = carries_word;
      result.run_last    = last_of_run;
      result.occupancy   = rfbp_pkg::OCC_W'(count);
      result.free_slots  = rfbp_pkg::OCC_W'(CAPACITY - count);
      result.is_empty    = (count == 0);
      result.is_full     = (count == CAPACITY);
      result.status_code = status;
      return result;
   endfunction

   // Updates the word store for one accepted request and queues the results
   // it should produce.
   task automatic predict_fifo_results(input rfbp_pkg::req_payload_type item);
      int run_len;
      int limit;
      logic [rfbp_pkg::WORD_W-1:0] word;
      case (item.req_type)
         rfbp_pkg::REQ_PUSH: begin
            if (held_words.size() >= CAPACITY) begin
               awaited_results.push_back(form_result('0, 1'b0, 1'b1,
                                                     rfbp_pkg::STATUS_DROPPED));
            end else begin
               held_words.push_back(item.push_value);
               awaited_results.push_back(form_result('0, 1'b0, 1'b1, rfbp_pkg::STATUS_OK));
            end
         end
         rfbp_pkg::REQ_POP: begin
            if (held_words.size() == 0) begin
               awaited_results.push_back(form_result('0, 1'b0, 1'b1,
                                                     rfbp_pkg::STATUS_EMPTY));
            end else begin
               // A limit of zero still removes one word.
               limit = (item.pop_limit == 0) ? 1 : int'(item.pop_limit);
               run_len = (limit < held_words.size()) ? limit : held_words.size();
               for (int i = 0; i < run_len; i++) begin
                  word = held_words.pop_front();
                  awaited_results.push_back(form_result(word, 1'b1, i == run_len - 1,
                                                        rfbp_pkg::STATUS_OK));
               end
            end
         end
         default: begin
            awaited_results.push_back(form_result('0, 1'b0, 1'b1, rfbp_pkg::STATUS_OK));
         end
      endcase
   endtask

   function automatic rfbp_pkg::req_payload_type make_request(
         logic [rfbp_pkg::TYPE_W-1:0] kind, logic [rfbp_pkg::WORD_W-1:0] value,
         logic [rfbp_pkg::LIMIT_W-1:0] limit);
      rfbp_pkg::req_payload_type item;
      item.req_type   = kind;
      item.push_value = value;
      item.pop_limit  = limit;
      return item;
   endfunction

   // Sends one request transaction. The task starts and ends at a rising edge.
   // The valid stays high after acceptance so that back-to-back requests never
   // lower and raise it within one time step.
   task automatic send_request(input rfbp_pkg::req_payload_type item);
      int gap;
      if (send_stretch_left == 0) begin
         send_calm = ($urandom_range(0, 3) == 0);
         send_stretch_left = $urandom_range(10, 40);
      end
      send_stretch_left--;
      gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_fifo_results(item);
   endtask

   task automatic test_empty_queue();
      send_request(make_request(REQ_QUERY, '0, 4'd1));
      send_request(make_request(rfbp_pkg::REQ_POP, '0, 4'd15));
   endtask

   // Fills the queue with extreme and random words, then pushes once more so
   // that the last push is dropped.
   task automatic test_fill_to_overflow();
      logic [rfbp_pkg::WORD_W-1:0] patterns[6];
      patterns = '{'0, ALL_ONES, {32{2'b10}}, {32{2'b01}}, 64'd1, {1'b1, 63'd0}};
      for (int i = 0; i < CAPACITY; i++) begin
         if (i < 6) begin
            send_request(make_request(rfbp_pkg::REQ_PUSH, patterns[i], '0));
         end else begin
            send_request(make_request(rfbp_pkg::REQ_PUSH, {$urandom, $urandom}, '0));
         end
      end
      send_request(make_request(rfbp_pkg::REQ_PUSH, ALL_ONES, 4'd15));
   endtask

   // Runs of one word, a few words, and a limit above the occupancy, then the
   // zero limit and the spare request code.
   task automatic test_bulk_pop_limits();
      send_request(make_request(rfbp_pkg::REQ_POP, '0, 4'd1));
      send_request(make_request(rfbp_pkg::REQ_POP, ALL_ONES, 4'd3));
      send_request(make_request(rfbp_pkg::REQ_POP, '0, 4'd15));
      send_request(make_request(rfbp_pkg::REQ_PUSH, {$urandom, $urandom}, '0));
      send_request(make_request(rfbp_pkg::REQ_PUSH, {$urandom, $urandom}, '0));
      send_request(make_request(REQ_SPARE, ALL_ONES, 4'd0));
      send_request(make_request(rfbp_pkg::REQ_POP, '0, 4'd0));
   endtask

   // Random traffic. The push share changes every few dozen requests so that
   // the fill level sweeps from empty to full.
   task automatic test_random_traffic();
      int push_share;
      int trend_left;
      int roll;
      logic [rfbp_pkg::WORD_W-1:0] value;
      logic [rfbp_pkg::LIMIT_W-1:0] limit;
      trend_left = 0;
      push_share = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (trend_left == 0) begin
            case ($urandom_range(0, 2))
               0: push_share = 25;
               1: push_share = 55;
               default: push_share = 85;
            endcase
            trend_left = $urandom_range(15, 45);
         end
         trend_left--;
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0) begin
            value = $urandom_range(0, 1) ? ALL_ONES : '0;
         end else begin
            value = {$urandom, $urandom};
         end
         limit = ($urandom_range(0, 15) == 0) ? 4'd0
                                               : rfbp_pkg::LIMIT_W'($urandom_range(1, 15));
         if (roll < 6) begin
            send_request(make_request($urandom_range(0, 1) ? REQ_QUERY : REQ_SPARE,
                                      value, limit));
         end else if (roll < 6 + push_share * 94 / 100) begin
            send_request(make_request(rfbp_pkg::REQ_PUSH, value, limit));
         end else begin
            send_request(make_request(rfbp_pkg::REQ_POP, value, limit));
         end
      end
   endtask

   // Receiver: draws a stall before each result, then compares the accepted
   // transaction field by field with the oldest expectation.
   initial begin
      int stall;
      rfbp_pkg::rsp_payload_type seen;
      rfbp_pkg::rsp_payload_type want;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (take_stretch_left == 0) begin
            take_calm = ($urandom_range(0, 3) == 0);
            take_stretch_left = $urandom_range(10, 40);
         end
         take_stretch_left--;
         stall = take_calm ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         seen = rsp_ch.payload;
         if (awaited_results.size() == 0) begin
            $error("result with no expectation waiting: %p", seen);
            failures++;
         end else begin
            want = awaited_results.pop_front();
            if (seen.data_word !== want.data_word) begin
               $error("data_word expected %h got %h", want.data_word, seen.data_word);
               failures++;
            end
            if (seen.data_valid !== want.data_valid) begin
               $error("data_valid expected %b got %b", want.data_valid, seen.data_valid);
               failures++;
            end
            if (seen.run_last !== want.run_last) begin
               $error("run_last expected %b got %b", want.run_last, seen.run_last);
               failures++;
            end
            if (seen.occupancy !== want.occupancy) begin
               $error("occupancy expected %0d got %0d", want.occupancy, seen.occupancy);
               failures++;
            end
            if (seen.free_slots !== want.free_slots) begin
               $error("free_slots expected %0d got %0d", want.free_slots, seen.free_slots);
               failures++;
            end
            if (seen.is_empty !== want.is_empty) begin
               $error("is_empty expected %b got %b", want.is_empty, seen.is_empty);
               failures++;
            end
            if (seen.is_full !== want.is_full) begin
               $error("is_full expected %b got %b", want.is_full, seen.is_full);
               failures++;
            end
            if (seen.status_code !== want.status_code) begin
               $error("status_code expected %0d got %0d", want.status_code,
                      seen.status_code);
               failures++;
            end
         end
      end
   end

   // Watchdog: a run of cycles with no transaction on either channel means the
   // block has hung. The longest legal quiet stretch is one sender gap or one
   // receiver stall, far below the limit.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("watchdog expired with %0d results outstanding", awaited_results.size());
      $display("== FAIL ==");
      $finish;
   end

   // Main sequence: reset once, the directed tests, random traffic, then drain.
   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_fill_to_overflow();
      test_bulk_pop_limits();
      test_random_traffic();

      req_ch.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      // Any stray result after the last expected one is caught by the receiver.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- ring_fifo_with_bulk_pop.f -----
design/rfbp_pkg.sv
design/rfbp_if.sv
design/rfbp_cell.sv
design/ring_fifo_with_bulk_pop.sv
dv/testbench.sv
